// File: design/cfr_pkg.sv
// Shared types, codes and constants of the clock frame replacement block.
package cfr_pkg;

    // Default number of frames the list and bit vectors are sized for
    localparam int unsigned FRAMES_DEF = 64;

    // Fixed field widths
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned FRAME_W  = 6;
    localparam int unsigned FCOUNT_W = 7;

    // Frame count after reset
    localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = 7'd64;

    // Request kinds
    localparam logic [FUNC_W-1:0] FUNC_TOUCH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

    // Result selection for the result holding registers
    localparam int unsigned RES_W = 3;
    localparam logic [RES_W-1:0] RES_NONE        = 3'd0;
    localparam logic [RES_W-1:0] RES_ECHO_OK     = 3'd1;
    localparam logic [RES_W-1:0] RES_ECHO_REJ    = 3'd2;
    localparam logic [RES_W-1:0] RES_ZERO_REJ    = 3'd3;
    localparam logic [RES_W-1:0] RES_GRANT_FREE  = 3'd4;
    localparam logic [RES_W-1:0] RES_GRANT_EVICT = 3'd5;

    // Request item
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FRAME_W-1:0] frame;
    } t_req;

    // Result item
    typedef struct packed {
        logic [FRAME_W-1:0] frame_out;
        logic               evicted;
        logic               status;
    } t_rsp;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             accept;
        logic             touch;
        logic             scan_start;
        logic             scan_next;
        logic             append_free;
        logic             rotate;
        logic             evict;
        logic             rel_start;
        logic             rel_step;
        logic             rel_finish;
        logic             out_load;
        logic [RES_W-1:0] res;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              frame_ok;
        logic              len_below;
        logic              len_zero;
        logic              scan_free;
        logic              scan_last;
        logic              head_ref;
        logic              rel_done;
        logic              out_free;
    } t_stat;

endpackage

// File: design/cfr_req_if.sv
// Request channel: valid, ready and one request item.
interface cfr_req_if;
    import cfr_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/cfr_rsp_if.sv
// Result channel: valid, ready and one result item.
interface cfr_rsp_if;
    import cfr_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/cfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/cfr_ctrl.sv
// Sequencer that steps each request through scan, rotation or release passes.
module cfr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cfr_pkg::t_stat i_stat,
    output cfr_pkg::t_cmd  o_cmd
);
    import cfr_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_ROT      = 3'd3;
    localparam logic [2:0] S_REL      = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;

    // Decide commands and next state
    always_comb begin
        cmd        = '0;
        cmd.res    = RES_NONE;
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if (i_stat.func == FUNC_ALLOC) begin
                    priority if (i_stat.len_below) begin
                        cmd.scan_start = 1'b1;
                        n_state        = S_SCAN;
                    end else if (i_stat.len_zero) begin
                        cmd.res = RES_ZERO_REJ;
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_ROT;
                    end
                end else if (i_stat.frame_ok && i_stat.func == FUNC_TOUCH) begin
                    cmd.touch = 1'b1;
                    cmd.res   = RES_ECHO_OK;
                    n_state   = S_FINISH;
                end else if (i_stat.frame_ok && i_stat.func == FUNC_RELEASE) begin
                    cmd.rel_start = 1'b1;
                    n_state       = S_REL;
                end else begin
                    cmd.res = RES_ECHO_REJ;
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                priority if (i_stat.scan_free) begin
                    cmd.append_free = 1'b1;
                    cmd.res         = RES_GRANT_FREE;
                    n_state         = S_FINISH;
                end else if (i_stat.scan_last) begin
                    if (i_stat.len_zero) begin
                        cmd.res = RES_ZERO_REJ;
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_ROT;
                    end
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_ROT: begin
                if (i_stat.head_ref) begin
                    cmd.rotate = 1'b1;
                end else begin
                    cmd.evict = 1'b1;
                    cmd.res   = RES_GRANT_EVICT;
                    n_state   = S_FINISH;
                end
            end
            S_REL: begin
                if (i_stat.rel_done) begin
                    cmd.rel_finish = 1'b1;
                    cmd.res        = RES_ECHO_OK;
                    n_state        = S_FINISH;
                end else begin
                    cmd.rel_step = 1'b1;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

endmodule

// File: design/cfr_dpath.sv
// Frame list RAM, referenced and busy bits, counters and result registers.
module cfr_dpath #(
    parameter int unsigned FRAMES = cfr_pkg::FRAMES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cfr_pkg::t_cmd                  i_cmd,
    output cfr_pkg::t_stat                 o_stat,
    input  logic                           i_cfg_we,
    input  logic [cfr_pkg::FCOUNT_W-1:0]   i_cfg_wdata,
    input  cfr_pkg::t_req                  i_req,
    output cfr_pkg::t_rsp                  o_rsp,
    output logic                           o_rsp_valid,
    input  logic                           i_rsp_ready
);
    import cfr_pkg::*;

    localparam int unsigned IW   = $clog2(FRAMES);
    localparam int unsigned LW   = $clog2(FRAMES + 1);
    localparam int unsigned SW   = LW + 1;
    localparam int unsigned CMPW = (LW > FCOUNT_W) ? LW : FCOUNT_W;

    // List position: head plus offset, wrapped once
    function automatic logic [IW-1:0] pos(input logic [IW-1:0] a, input logic [LW-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (s >= SW'(FRAMES)) begin
            s = s - SW'(FRAMES);
        end
        return s[IW-1:0];
    endfunction

    logic [FCOUNT_W-1:0] r_fcount;
    logic [FUNC_W-1:0]   r_func;
    logic [FRAME_W-1:0]  r_frame;
    logic [IW-1:0]       r_head, n_head;
    logic [LW-1:0]       r_len, n_len;
    logic [LW-1:0]       r_cnt, n_cnt;
    logic                r_pend, n_pend;
    logic                r_found, n_found;
    logic [FRAMES-1:0]   r_busy, n_busy;
    logic [FRAMES-1:0]   r_ref, n_ref;
    logic                r_fwd;
    logic [IW-1:0]       r_fwd_data;
    logic [FRAME_W-1:0]  r_res_frame;
    logic                r_res_ev;
    logic                r_res_st;
    logic                r_out_valid;
    t_rsp                r_out;

    logic                we;
    logic [IW-1:0]       waddr;
    logic [IW-1:0]       wdata;
    logic [IW-1:0]       raddr;
    logic [IW-1:0]       ram_rdata;
    logic [IW-1:0]       d;
    logic [IW-1:0]       tail;
    logic [IW-1:0]       cnt_idx;
    logic [CMPW-1:0]     fc_ext;
    logic [CMPW-1:0]     frame_ext;
    logic [IW-1:0]       frame_idx;
    logic [LW-1:0]       n_use;
    logic                match;

    // Clamp the frame count to the supported range
    always_comb begin
        fc_ext = CMPW'(r_fcount);
        priority if (fc_ext < CMPW'(2)) begin
            n_use = LW'(2);
        end else if (fc_ext > CMPW'(FRAMES)) begin
            n_use = LW'(FRAMES);
        end else begin
            n_use = fc_ext[LW-1:0];
        end
    end

    assign frame_ext = CMPW'(r_frame);
    assign frame_idx = frame_ext[IW-1:0];
    assign cnt_idx   = r_cnt[IW-1:0];
    assign tail      = pos(r_head, r_len);
    assign d         = r_fwd ? r_fwd_data : ram_rdata;
    assign match     = (CMPW'(d) == frame_ext);

    // Status to the controller
    always_comb begin
        o_stat.func      = r_func;
        o_stat.frame_ok  = (frame_ext != '0) && (frame_ext < CMPW'(n_use));
        o_stat.len_below = (r_len < (n_use - LW'(1)));
        o_stat.len_zero  = (r_len == '0);
        o_stat.scan_free = !r_busy[cnt_idx];
        o_stat.scan_last = (r_cnt == (n_use - LW'(1)));
        o_stat.head_ref  = r_ref[d];
        o_stat.rel_done  = !r_pend && (r_cnt == r_len);
        o_stat.out_free  = !r_out_valid || i_rsp_ready;
    end

    // Next list, bit and counter state
    always_comb begin
        n_busy  = r_busy;
        n_ref   = r_ref;
        n_head  = r_head;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_pend  = r_pend;
        n_found = r_found;
        we      = 1'b0;
        waddr   = tail;
        wdata   = d;

        if (i_cmd.touch) begin
            n_ref[frame_idx] = 1'b1;
        end
        if (i_cmd.scan_start) begin
            n_cnt = LW'(1);
        end
        if (i_cmd.scan_next) begin
            n_cnt = r_cnt + LW'(1);
        end
        // Grant the free frame and append it at the tail
        if (i_cmd.append_free) begin
            we               = 1'b1;
            wdata            = cnt_idx;
            n_busy[cnt_idx]  = 1'b1;
            n_ref[cnt_idx]   = 1'b1;
            if (r_len < LW'(FRAMES)) begin
                n_len = r_len + LW'(1);
            end
        end
        // Move a referenced head to the tail, clearing its bit
        if (i_cmd.rotate) begin
            we       = 1'b1;
            n_ref[d] = 1'b0;
            n_head   = pos(r_head, LW'(1));
        end
        // Evict the head and append it again as the new grant
        if (i_cmd.evict) begin
            we        = 1'b1;
            n_ref[d]  = 1'b1;
            n_busy[d] = 1'b1;
            n_head    = pos(r_head, LW'(1));
        end
        if (i_cmd.rel_start) begin
            n_cnt   = '0;
            n_pend  = 1'b0;
            n_found = 1'b0;
        end
        // Search the list and close the gap behind the match
        if (i_cmd.rel_step) begin
            if (r_cnt < r_len) begin
                n_cnt  = r_cnt + LW'(1);
                n_pend = 1'b1;
            end else begin
                n_pend = 1'b0;
            end
            if (r_pend) begin
                if (r_found) begin
                    we    = 1'b1;
                    waddr = pos(r_head, r_cnt - LW'(2));
                end else if (match) begin
                    n_found = 1'b1;
                end
            end
        end
        if (i_cmd.rel_finish) begin
            n_busy[frame_idx] = 1'b0;
            n_ref[frame_idx]  = 1'b0;
            if (r_found) begin
                n_len = r_len - LW'(1);
            end
        end
        raddr = i_cmd.rel_step ? pos(r_head, r_cnt) : n_head;
    end

    cfr_ram #(
        .WIDTH (IW),
        .DEPTH (FRAMES)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcount    <= FCOUNT_RESET;
            r_head      <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_busy      <= FRAMES'(1);
            r_ref       <= '0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fcount <= i_cfg_wdata;
            end
            r_head  <= n_head;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_found <= n_found;
            r_busy  <= n_busy;
            r_ref   <= n_ref;
            r_fwd   <= we && (waddr == raddr);
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request, bypass and result payload
    always_ff @(posedge i_clk) begin
        r_fwd_data <= wdata;
        if (i_cmd.accept) begin
            r_func  <= i_req.func;
            r_frame <= i_req.frame;
        end
        unique case (i_cmd.res)
            RES_ECHO_OK: begin
                r_res_frame <= r_frame;
                r_res_ev    <= 1'b0;
                r_res_st    <= 1'b0;
            end
            RES_ECHO_REJ: begin
                r_res_frame <= r_frame;
                r_res_ev    <= 1'b0;
                r_res_st    <= 1'b1;
            end
            RES_ZERO_REJ: begin
                r_res_frame <= '0;
                r_res_ev    <= 1'b0;
                r_res_st    <= 1'b1;
            end
            RES_GRANT_FREE: begin
                r_res_frame <= FRAME_W'(r_cnt);
                r_res_ev    <= 1'b0;
                r_res_st    <= 1'b0;
            end
            RES_GRANT_EVICT: begin
                r_res_frame <= FRAME_W'(d);
                r_res_ev    <= 1'b1;
                r_res_st    <= 1'b0;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_out.frame_out <= r_res_frame;
            r_out.evicted   <= r_res_ev;
            r_out.status    <= r_res_st;
        end
    end

    assign o_rsp       = r_out;
    assign o_rsp_valid = r_out_valid;

    // A rotation leaves the list length unchanged
    a_rotate_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rotate |=> $stable(r_len))
        else $error("rotation changed list length");

    // Removing a listed frame shortens the list by one
    a_release_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rel_finish && r_found) |=> (r_len == $past(r_len) - LW'(1)))
        else $error("release did not shorten list");

    // An evicted frame is granted busy and referenced
    a_evict_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict |=> (r_ref[$past(d)] && r_busy[$past(d)]))
        else $error("evicted frame not marked busy and referenced");

    // A free grant grows the list by one
    a_append_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append_free |=> (r_len == $past(r_len) + LW'(1)))
        else $error("free grant did not grow list");

endmodule

// File: design/clock_frame_replacement_top.sv
// Top level of the second-chance clock frame replacement block.
//
// Requests enter on i_req (touch, allocate or release of a frame) and each gives
// exactly one result item on o_rsp, in request order. The frame count register is
// written through i_cfg_we / i_cfg_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce it.
// One request is worked on at a time. An allocate scans the busy bits for a free
// frame while the list has room; otherwise, or when none is free, it rotates
// referenced frames past the head and evicts the first unreferenced one. A release
// walks the list and closes the gap behind the listed frame.
// The controller returns to idle when the result loads and takes the next request
// from there. The busy-bit scan checks one frame a cycle, and the single read port
// of the list RAM moves one list entry per cycle in rotation and release.
// The result sits in an output register; a new request is taken while it waits,
// and a finished request holds until the register frees. A stalled receiver
// therefore holds at most one finished and one working request.
// Reset (synchronous, active low) empties the list, clears all referenced bits,
// marks only frame zero busy and sets the frame count to 64; no clearing pass.
module clock_frame_replacement_top #(
    parameter int unsigned FRAMES = cfr_pkg::FRAMES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cfr_pkg::FCOUNT_W-1:0] i_cfg_wdata,
    cfr_req_if.sink                      i_req,
    cfr_rsp_if.source                    o_rsp
);
    import cfr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cfr_dpath #(
        .FRAMES (FRAMES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req.data),
        .o_rsp       (o_rsp.data),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready)
    );

endmodule

// File: tb/sv/clock_frame_replacement_top_test.sv
// Self-checking test of the second-chance clock frame replacement block.
`timescale 1ns / 1ps

module clock_frame_replacement_top_test;
    import cfr_pkg::*;

    localparam int unsigned FRAMES      = FRAMES_DEF;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 160;
    localparam int SETTLE      = 200;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        t_req rq;
        bit   drain;
    } t_pending;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [FCOUNT_W-1:0] i_cfg_wdata;

    cfr_req_if req_if ();
    cfr_rsp_if rsp_if ();

    clock_frame_replacement_top #(.FRAMES(FRAMES)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // Stimulus backlog, results still due, and progress counters
    t_pending req_backlog[$];
    t_rsp     due_rsp[$];
    int       queued_total;
    int       checked_total;
    int       fault_count;
    int       send_idle_pct;
    int       recv_idle_pct;

    // Predicted state of the replacement policy
    logic [FRAME_W-1:0]  order_q [FRAMES];
    int unsigned         order_len;
    bit                  ref_bit [FRAMES];
    bit                  busy_bit [FRAMES];
    logic [FCOUNT_W-1:0] frame_count;

    // Apply one request to the predicted state and return the result item
    function automatic t_rsp clock_policy_step(t_req rq);
        t_rsp r;
        int unsigned n;
        int unsigned i;
        int unsigned j;
        int unsigned guard;
        logic [FRAME_W-1:0] head;
        bit found;
        n = (frame_count < 2) ? 2 : (frame_count > FRAMES) ? FRAMES : frame_count;
        r.frame_out = rq.frame;
        r.evicted = 1'b0;
        r.status = 1'b0;
        found = 1'b0;
        if (rq.func == FUNC_ALLOC) begin
            // grant the lowest free frame while the list has room
            if (order_len < n - 1) begin
                for (i = 1; i < n; i++) begin
                    if (!busy_bit[i]) begin
                        r.frame_out = FRAME_W'(i);
                        found = 1'b1;
                        break;
                    end
                end
            end
            if (!found) begin
                if (order_len == 0) begin
                    r.frame_out = '0;
                    r.status = 1'b1;
                end else begin
                    // rotate referenced frames to the tail, clearing their bits
                    guard = 0;
                    while (guard <= order_len) begin
                        head = order_q[0];
                        if (!ref_bit[head]) break;
                        ref_bit[head] = 1'b0;
                        for (j = 0; j + 1 < order_len; j++) order_q[j] = order_q[j + 1];
                        order_q[order_len - 1] = head;
                        guard++;
                    end
                    // evict the head
                    head = order_q[0];
                    for (j = 0; j + 1 < order_len; j++) order_q[j] = order_q[j + 1];
                    order_len--;
                    r.frame_out = head;
                    r.evicted = 1'b1;
                end
            end
            if (!r.status) begin
                busy_bit[r.frame_out] = 1'b1;
                ref_bit[r.frame_out] = 1'b1;
                if (order_len < FRAMES) begin
                    order_q[order_len] = r.frame_out;
                    order_len++;
                end
            end
        end else if ((rq.func == FUNC_TOUCH || rq.func == FUNC_RELEASE) &&
                     rq.frame != 0 && rq.frame < n) begin
            if (rq.func == FUNC_TOUCH) begin
                ref_bit[rq.frame] = 1'b1;
            end else begin
                // drop from the list, keeping the order of the rest
                for (i = 0; i < order_len; i++) begin
                    if (order_q[i] == rq.frame) begin
                        for (j = i; j + 1 < order_len; j++) order_q[j] = order_q[j + 1];
                        order_len--;
                        break;
                    end
                end
                busy_bit[rq.frame] = 1'b0;
                ref_bit[rq.frame] = 1'b0;
            end
        end else begin
            r.status = 1'b1;
        end
        return r;
    endfunction

    task automatic queue_item(input logic [FUNC_W-1:0] f, input logic [FRAME_W-1:0] fr,
                              input bit drain = 1'b0);
        t_pending p;
        p.rq.func = f;
        p.rq.frame = fr;
        p.drain = drain;
        req_backlog = {req_backlog, p};
        queued_total++;
    endtask

    // Wait until every queued item has its result, then let the block settle
    task automatic wait_idle();
        while (checked_total != queued_total) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_frame_count(input logic [FCOUNT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        frame_count = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Driver: offer items from the backlog, hold each until accepted
    always @(posedge i_clk) begin
        t_pending nxt;
        t_rsp     pred;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                pred = clock_policy_step(req_if.data);
                due_rsp = {due_rsp, pred};
            end
            if (!req_if.valid || req_if.ready) begin
                if (req_backlog.size() > 0 &&
                    !(req_backlog[0].drain && due_rsp.size() > 0) &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = req_backlog[0];
                    req_backlog.delete(0);
                    req_if.valid <= 1'b1;
                    req_if.data <= nxt.rq;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result item against the oldest one due
    always @(posedge i_clk) begin
        t_rsp want;
        int hold_left;
        bit hold_done;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (due_rsp.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 40)
                        $display("%0t: unexpected result frame_out=%0d evicted=%0d status=%0d",
                                 $time, rsp_if.data.frame_out, rsp_if.data.evicted,
                                 rsp_if.data.status);
                end else begin
                    want = due_rsp[0];
                    due_rsp.delete(0);
                    if (rsp_if.data.frame_out !== want.frame_out ||
                        rsp_if.data.evicted !== want.evicted ||
                        rsp_if.data.status !== want.status) begin
                        fault_count++;
                        if (fault_count <= 40)
                            $display({"%0t: mismatch expected frame_out=%0d evicted=%0d ",
                                      "status=%0d, got frame_out=%0d evicted=%0d status=%0d"},
                                     $time, want.frame_out, want.evicted, want.status,
                                     rsp_if.data.frame_out, rsp_if.data.evicted,
                                     rsp_if.data.status);
                    end
                    checked_total++;
                end
            end
            // once, hold off long enough for the block to back up its input
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (!hold_done && checked_total >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Sequence: reset, directed items, then random phases over several frame counts
    initial begin
        int cfg_vals [PHASES] = '{64, 2, 127, 9, 1, 33, 0, 100, 17, 64};
        int n;
        int alloc_pct;
        int sel;
        int ph;
        int k;
        t_req rq;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        queued_total = 0;
        checked_total = 0;
        fault_count = 0;
        send_idle_pct = 22;
        recv_idle_pct = 59;
        for (k = 0; k < FRAMES; k++) begin
            order_q[k] = '0;
            ref_bit[k] = 1'b0;
            busy_bit[k] = 1'b0;
        end
        busy_bit[0] = 1'b1;
        order_len = 0;
        frame_count = FCOUNT_RESET;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // top frame at the reset count, release of an unlisted frame, unused code
        queue_item(FUNC_TOUCH, 6'd63);
        queue_item(FUNC_RELEASE, 6'd63);
        queue_item(FUNC_UNUSED, 6'd42);
        wait_idle();

        // small count: rejects, free grants, eviction, release in and out of the list
        write_frame_count(7'd4);
        queue_item(FUNC_TOUCH, 6'd0);
        queue_item(FUNC_RELEASE, 6'd0);
        queue_item(FUNC_TOUCH, 6'd4);
        queue_item(FUNC_RELEASE, 6'd63);
        queue_item(FUNC_UNUSED, 6'd0);
        queue_item(FUNC_UNUSED, 6'd63);
        queue_item(FUNC_TOUCH, 6'd3);
        queue_item(FUNC_ALLOC, 6'd63);
        queue_item(FUNC_ALLOC, 6'd0);
        queue_item(FUNC_ALLOC, 6'd21);
        queue_item(FUNC_ALLOC, 6'd42);
        queue_item(FUNC_TOUCH, 6'd2);
        queue_item(FUNC_ALLOC, 6'd5);
        queue_item(FUNC_RELEASE, 6'd2);
        queue_item(FUNC_RELEASE, 6'd2);
        queue_item(FUNC_ALLOC, 6'd9);
        queue_item(FUNC_RELEASE, 6'd1);
        queue_item(FUNC_TOUCH, 6'd1);
        wait_idle();

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph < 4) begin
                send_idle_pct = 22;
                recv_idle_pct = 59;
            end else if (ph < 7) begin
                send_idle_pct = 59;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_frame_count(FCOUNT_W'(cfg_vals[ph]));
            n = (cfg_vals[ph] < 2) ? 2 : (cfg_vals[ph] > FRAMES) ? FRAMES : cfg_vals[ph];
            alloc_pct = (n > 16) ? 55 : 35;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 85) rq.frame = FRAME_W'($urandom_range(1, n - 1));
                else rq.frame = FRAME_W'($urandom_range(0, 63));
                if (sel < alloc_pct) begin
                    rq.func = FUNC_ALLOC;
                    rq.frame = FRAME_W'($urandom_range(0, 63));
                end else if (sel < alloc_pct + (95 - alloc_pct) * 2 / 3) begin
                    rq.func = FUNC_TOUCH;
                end else if (sel < 95) begin
                    rq.func = FUNC_RELEASE;
                end else begin
                    rq.func = FUNC_UNUSED;
                end
                // mid-phase, pause the sender until the block has drained
                queue_item(rq.func, rq.frame, k == PHASE_ITEMS / 2);
            end
            wait_idle();
        end

        if (fault_count == 0 && due_rsp.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
design/cfr_pkg.sv
design/cfr_req_if.sv
design/cfr_rsp_if.sv
design/cfr_ram.sv
design/cfr_ctrl.sv
design/cfr_dpath.sv
design/clock_frame_replacement_top.sv
tb/sv/clock_frame_replacement_top_test.sv
